@@ rtl/irdf_pkg.sv @@
// Shared types and constants for the integer radix digit formatter.
// No dependencies; imported by integer_radix_digit_formatter_unit.
package irdf_pkg;

  localparam int STEP_BITS = 8;
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int CHAR_W    = 7;

  localparam logic [2:0] LEN_CHAR  = 3'd0;
  localparam logic [2:0] LEN_SHORT = 3'd1;
  localparam logic [2:0] LEN_INT   = 3'd2;

  localparam logic       KIND_SIGNED = 1'b0;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t DIGITS_UPPER [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  localparam char_t DIGITS_LOWER [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };

endpackage

@@ rtl/integer_radix_digit_formatter_unit.sv @@
// Integer to ASCII digit formatter, one word in, one digit word out at a time.
// Operation: the value is loaded, then each digit is computed on the shared
// 8-bit-per-cycle long divider; the digits are then read back, most significant first,
// and sent. Input is stalled while busy, so one word is formatted at a time.
// Reset: synchronous; clears the sequencer and the output valid, digit store needs none.
// Depends on irdf_pkg.
module integer_radix_digit_formatter_unit #(
  parameter int VALUE_BITS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     kind,
  input  logic [63:0]              value,
  input  logic [2:0]               length_code,
  input  logic [4:0]               radix,
  input  logic                     uppercase,
  output logic                     out_valid,
  input  logic                     out_stall,
  output irdf_pkg::char_t          digit_char,
  output logic                     negative,
  output logic                     last_digit
);
  import irdf_pkg::*;

  localparam int CHUNKS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_BITS = CHUNKS * STEP_BITS;
  localparam int CHUNK_W  = $clog2(CHUNKS);
  localparam int ADDR_W   = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_READ, S_SHOW, S_HOLD} state_t;

  state_t               state;
  logic [CHUNK_W-1:0]   chunk;
  logic [ADDR_W-1:0]    ptr;
  logic [DIV_BITS-1:0]  quo;
  logic [DIGIT_W-1:0]   rem;
  logic [RADIX_W-1:0]   rad;
  logic                 upper;
  logic                 neg;
  logic [DIGIT_W-1:0]   digit_mem [VALUE_BITS];
  logic [DIGIT_W-1:0]   rd_digit;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mask;
  logic [VALUE_BITS-1:0] masked;
  logic [VALUE_BITS-1:0] mag;
  logic                  sign_bit;
  logic                  is_neg;
  logic [RADIX_W-1:0]    rad_in;

  logic [STEP_BITS-1:0]  top_bits;
  logic [STEP_BITS-1:0]  q_bits;
  logic [RADIX_W-1:0]    r_step;
  logic [DIGIT_W-1:0]    rem_next;
  logic [DIV_BITS-1:0]   quo_next;
  logic                  last_chunk;
  logic                  in_acc;
  logic                  out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    raw = value[VALUE_BITS-1:0];
    case (length_code)
      LEN_CHAR: begin
        mask     = ~({VALUE_BITS{1'b1}} << 8);
        sign_bit = raw[7];
      end
      LEN_SHORT: begin
        mask     = ~({VALUE_BITS{1'b1}} << 16);
        sign_bit = raw[15];
      end
      LEN_INT: begin
        mask     = ~({VALUE_BITS{1'b1}} << 32);
        sign_bit = raw[31];
      end
      default: begin
        mask     = {VALUE_BITS{1'b1}};
        sign_bit = raw[VALUE_BITS-1];
      end
    endcase
    masked = raw & mask;
    is_neg = (kind == KIND_SIGNED) && sign_bit;
    mag    = is_neg ? ((~masked + 1'b1) & mask) : masked;
    if (radix < RADIX_MIN) begin
      rad_in = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      rad_in = RADIX_MAX;
    end else begin
      rad_in = radix;
    end
  end

  always_comb begin
    top_bits = quo[DIV_BITS-1 -: STEP_BITS];
    r_step   = {1'b0, rem};
    q_bits   = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      r_step = {r_step[DIGIT_W-1:0], top_bits[i]};
      if (r_step >= rad) begin
        r_step    = r_step - rad;
        q_bits[i] = 1'b1;
      end
    end
    rem_next   = r_step[DIGIT_W-1:0];
    quo_next   = {quo[DIV_BITS-STEP_BITS-1:0], q_bits};
    last_chunk = (chunk == CHUNK_W'(CHUNKS - 1));
  end

  always_ff @(posedge clk) begin
    if (state == S_DIV && last_chunk) begin
      digit_mem[ptr] <= rem_next;
    end
    rd_digit <= digit_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chunk     <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            quo   <= DIV_BITS'(mag);
            rem   <= '0;
            rad   <= rad_in;
            upper <= uppercase;
            neg   <= is_neg;
            chunk <= '0;
            ptr   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          quo <= quo_next;
          if (last_chunk) begin
            chunk <= '0;
            rem   <= '0;
            if (quo_next == '0) begin
              state <= S_READ;
            end else begin
              ptr <= ptr + 1'b1;
            end
          end else begin
            chunk <= chunk + 1'b1;
            rem   <= rem_next;
          end
        end
        S_READ: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          digit_char <= upper ? DIGITS_UPPER[rd_digit] : DIGITS_LOWER[rd_digit];
          negative   <= neg;
          last_digit <= (ptr == '0);
          out_valid  <= 1'b1;
          state      <= S_HOLD;
        end
        S_HOLD: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            if (last_digit) begin
              state <= S_IDLE;
            end else begin
              ptr   <= ptr - 1'b1;
              state <= S_READ;
            end
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  a_idle_no_output: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("Output word valid while the unit takes input.");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (out_acc && last_digit) |=> !in_stall)
    else $error("Unit did not return to idle after the final digit.");

  a_more_digits_busy: assert property (@(posedge clk) disable iff (rst)
    (out_acc && !last_digit) |=> in_stall && !out_valid)
    else $error("Unit left the item before its final digit.");

  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rad >= RADIX_MIN && rad <= RADIX_MAX && rem < rad))
    else $error("Divider radix or remainder out of range.");

endmodule
